>>> rtl/core/pdjs_pkg.sv
// Shared types, widths and codes for the PD joint servo with phase hold.
// No dependencies; every other file of the block except pdjs_ram refers to this package.
package pdjs_pkg;

  localparam int NUM_JOINTS_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int JOINT_W    = 5;
  localparam int ANG_W      = 24;
  localparam int GAIN_W     = 24;
  localparam int TRQ_W      = 32;
  localparam int THR_W      = 31;
  localparam int RATE_W     = 16;
  localparam int PHASE_W    = 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int CFG_IDX_BIT = 2;

  // Shared multiplier: a 33-bit signed operand times a 25-bit signed operand.
  localparam int ERR_W      = ANG_W + 1;
  localparam int MUL_A_W    = TRQ_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // Products carry 20 fraction bits, results 16.
  localparam int RND_SHIFT  = 4;
  localparam int ROUND_BIAS = 1 << (RND_SHIFT - 1);

  localparam logic [THR_W-1:0]  THR_RESET  = 31'd1966080;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd500;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_GAINS = 2'd0,
    CMD_ACTIVATE   = 2'd1,
    CMD_CONTROL    = 2'd2
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_HOLD   = 2'd2
  } phase_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_RATE      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PMUL,
    ST_DMUL,
    ST_SUM
  } fsm_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [JOINT_W-1:0]        joint;
    logic signed [ANG_W-1:0]   angle;
    logic signed [ANG_W-1:0]   ref_angle;
    logic signed [ANG_W-1:0]   ref_velocity;
    logic                      first_has_row;
    logic                      second_has_row;
    logic signed [TRQ_W-1:0]   right_torque;
    logic signed [TRQ_W-1:0]   left_torque;
    logic [GAIN_W-1:0]         p_gain;
    logic [GAIN_W-1:0]         d_gain;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        out_joint;
    logic signed [TRQ_W-1:0]   torque;
    logic [PHASE_W-1:0]        phase;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]          threshold;
    logic [RATE_W-1:0]         sample_rate;
  } cfg_t;

endpackage

>>> rtl/core/pdjs_in_if.sv
// Valid/ready channel carrying one servo command beat.
// Depends on pdjs_pkg for the payload type.
interface pdjs_in_if;
  logic               valid;
  logic               ready;
  pdjs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pdjs_out_if.sv
// Valid/ready channel carrying one torque result beat.
// Depends on pdjs_pkg for the payload type.
interface pdjs_out_if;
  logic                valid;
  logic                ready;
  pdjs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pd_joint_servo_with_phase_hold.sv
// Top level of the PD joint servo with trajectory phase hold.
// Depends on pdjs_pkg, pdjs_in_if, pdjs_out_if, pdjs_ram and pdjs_cfg_regs.

// The block runs a PD position loop for up to NUM_JOINTS joints, one command
// beat at a time. A gain load and an activate give no result. A control step
// produces one torque beat: the accepting edge reads the joint's state and
// gain memories, then three passes through a single shared 33x25-bit signed
// multiplier (velocity scaling, proportional product, derivative product),
// one per cycle, and a final sum, round and clip step that loads the output
// register. No further command beat is taken until that sequence has ended.
// A finished torque sits in an output register, so the next command beat is
// taken while the result waits; only the final cycle of a control step waits
// for that register to free up. Held references are masked by per-joint valid
// bits that reset clears at once, so no clearing pass follows reset. The
// playback phase advances only on control steps for joint 0.
module pd_joint_servo_with_phase_hold #(
  parameter int NUM_JOINTS = pdjs_pkg::NUM_JOINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pdjs_in_if.sink                         in_chan,
  pdjs_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdjs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pdjs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pdjs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IDX_W  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int ANG_W  = pdjs_pkg::ANG_W;
  localparam int GAIN_W = pdjs_pkg::GAIN_W;
  localparam int TRQ_W  = pdjs_pkg::TRQ_W;
  localparam int ERR_W  = pdjs_pkg::ERR_W;
  localparam int PROD_W = pdjs_pkg::PROD_W;
  localparam int ST_W   = 2 * ANG_W;
  localparam int GN_W   = 2 * GAIN_W;
  localparam int ABS_W  = TRQ_W + 1;

  // Saturate a wide signed value to the torque width; the top bit of the
  // return value flags a clip.
  function automatic logic [TRQ_W:0] clip_trq(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-TRQ_W:0] hi;
    logic                  fits;
    logic [TRQ_W-1:0]      lim;
    hi   = v[PROD_W-1:TRQ_W-1];
    fits = (&hi) || !(|hi);
    lim  = v[PROD_W-1] ? {1'b1, {(TRQ_W-1){1'b0}}} : {1'b0, {(TRQ_W-1){1'b1}}};
    return fits ? {1'b0, v[TRQ_W-1:0]} : {1'b1, lim};
  endfunction

  pdjs_pkg::cfg_t cfg;

  pdjs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Accept decode. A joint beyond the table leaves every bit of state alone.
  pdjs_pkg::in_item_t in_d;
  logic               in_ready;
  logic               fire, in_range, is_ctl, is_act, is_gain, joint_zero;
  logic [IDX_W-1:0]   in_idx;

  assign in_d       = in_chan.data;
  assign fire       = in_chan.valid && in_ready;
  assign in_range   = 32'(in_d.joint) < 32'(NUM_JOINTS);
  assign in_idx     = IDX_W'(in_d.joint);
  assign joint_zero = (in_d.joint == '0);
  assign is_ctl     = fire && in_range && (in_d.cmd == pdjs_pkg::CMD_CONTROL);
  assign is_act     = fire && in_range && (in_d.cmd == pdjs_pkg::CMD_ACTIVATE);
  assign is_gain    = fire && in_range && (in_d.cmd == pdjs_pkg::CMD_LOAD_GAINS);

  // Playback phase and the one-shot foot torque check.
  pdjs_pkg::phase_t phase_r, phase_nxt, phase_upd, item_phase;
  logic             armed_r, armed_nxt, armed_upd;
  logic signed [ABS_W-1:0] rt_x, lt_x;
  logic [ABS_W-1:0]        abs_rt, abs_lt, thr_x;
  logic                    light_foot;

  assign rt_x       = ABS_W'(in_d.right_torque);
  assign lt_x       = ABS_W'(in_d.left_torque);
  assign abs_rt     = rt_x[ABS_W-1] ? -rt_x : rt_x;
  assign abs_lt     = lt_x[ABS_W-1] ? -lt_x : lt_x;
  assign thr_x      = ABS_W'(cfg.threshold);
  assign light_foot = (abs_rt < thr_x) || (abs_lt < thr_x);

  always_comb begin
    phase_upd = phase_r;
    armed_upd = armed_r;
    if (phase_r == pdjs_pkg::PHASE_FIRST && !in_d.first_has_row) begin
      phase_upd = pdjs_pkg::PHASE_SECOND;
    end
    if (phase_upd == pdjs_pkg::PHASE_SECOND) begin
      if (!in_d.second_has_row || (armed_r && light_foot)) begin
        phase_upd = pdjs_pkg::PHASE_HOLD;
      end
      armed_upd = 1'b0;
    end
  end

  assign item_phase = joint_zero ? phase_upd : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    armed_nxt = armed_r;
    priority if (is_act) begin
      phase_nxt = pdjs_pkg::PHASE_FIRST;
      armed_nxt = 1'b1;
    end else if (is_ctl && joint_zero) begin
      phase_nxt = phase_upd;
      armed_nxt = armed_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pdjs_pkg::PHASE_FIRST;
      armed_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Sequencer.
  pdjs_pkg::fsm_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt, out_free, fin;

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdjs_pkg::ST_IDLE: if (is_ctl) begin
        state_nxt = pdjs_pkg::ST_READ;
      end
      pdjs_pkg::ST_READ: state_nxt = pdjs_pkg::ST_PMUL;
      pdjs_pkg::ST_PMUL: state_nxt = pdjs_pkg::ST_DMUL;
      pdjs_pkg::ST_DMUL: state_nxt = pdjs_pkg::ST_SUM;
      pdjs_pkg::ST_SUM: if (out_free) begin
        state_nxt = pdjs_pkg::ST_IDLE;
      end
      default: state_nxt = pdjs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    fin      = 1'b0;
    unique case (state_r)
      pdjs_pkg::ST_IDLE: in_ready = 1'b1;
      pdjs_pkg::ST_SUM:  fin      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdjs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_chan.ready = in_ready;

  // Per-joint state memory {previous angle, held reference} and gain memory
  // {P, D}. Both are read when a control step is accepted; the read data
  // stays put until the next control step.
  logic             st_we;
  logic [IDX_W-1:0] st_waddr, idx_r;
  logic [ST_W-1:0]  st_wdata, st_rdata;
  logic [GN_W-1:0]  gn_rdata;

  pdjs_ram #(.WIDTH(ST_W), .DEPTH(NUM_JOINTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (is_ctl),
    .raddr (in_idx),
    .rdata (st_rdata)
  );

  pdjs_ram #(.WIDTH(GN_W), .DEPTH(NUM_JOINTS)) u_gain_ram (
    .clk   (clk),
    .we    (is_gain),
    .waddr (in_idx),
    .wdata ({in_d.p_gain, in_d.d_gain}),
    .re    (is_ctl),
    .raddr (in_idx),
    .rdata (gn_rdata)
  );

  // Item registers captured when a control step is accepted.
  logic [pdjs_pkg::JOINT_W-1:0] joint_r;
  logic signed [ANG_W-1:0]      q_r, refq_r, refdq_r, held_new_r;
  logic                         hold_r;
  pdjs_pkg::phase_t             item_phase_r;

  always_ff @(posedge clk) begin
    if (is_ctl) begin
      joint_r      <= in_d.joint;
      idx_r        <= in_idx;
      q_r          <= in_d.angle;
      refq_r       <= in_d.ref_angle;
      refdq_r      <= in_d.ref_velocity;
      hold_r       <= (item_phase == pdjs_pkg::PHASE_HOLD);
      item_phase_r <= item_phase;
    end
  end

  // A held reference that was never written reads as zero.
  logic [NUM_JOINTS-1:0]   vld_r;
  logic signed [ANG_W-1:0] prev_ang, held_ang, qref;
  logic signed [ERR_W-1:0] dq, perr;

  assign prev_ang = $signed(st_rdata[ST_W-1 -: ANG_W]);
  assign held_ang = vld_r[idx_r] ? $signed(st_rdata[ANG_W-1:0]) : '0;
  assign qref     = hold_r ? held_ang : refq_r;
  assign dq       = ERR_W'(q_r) - ERR_W'(prev_ang);
  assign perr     = ERR_W'(q_r) - ERR_W'(qref);

  // Shared multiplier; its operands follow the sequencer step.
  logic signed [pdjs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pdjs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]            prod;
  logic signed [PROD_W-1:0]            prod_r, pprod_r;
  logic signed [ERR_W-1:0]             perr_r;
  logic signed [TRQ_W-1:0]             verr_r;
  logic                                sat_r;

  always_comb begin
    unique case (state_r)
      pdjs_pkg::ST_READ: begin
        mul_a = pdjs_pkg::MUL_A_W'(dq);
        mul_b = $signed(pdjs_pkg::MUL_B_W'(cfg.sample_rate));
      end
      pdjs_pkg::ST_PMUL: begin
        mul_a = pdjs_pkg::MUL_A_W'(perr_r);
        mul_b = $signed(pdjs_pkg::MUL_B_W'(gn_rdata[GN_W-1 -: GAIN_W]));
      end
      pdjs_pkg::ST_DMUL: begin
        mul_a = pdjs_pkg::MUL_A_W'(verr_r);
        mul_b = $signed(pdjs_pkg::MUL_B_W'(gn_rdata[GAIN_W-1:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Velocity error: scaled angle step less the reference velocity (zero in
  // hold), clipped to the torque width.
  logic signed [PROD_W-1:0] dqref_x, vraw, sum, shifted;
  logic [TRQ_W:0]           vclip, tclip;

  assign dqref_x = hold_r ? '0 : PROD_W'(refdq_r);
  assign vraw    = prod_r - dqref_x;
  assign vclip   = clip_trq(vraw);

  // Torque: negated sum of both products, rounded to 16 fraction bits
  // toward minus infinity after a half-step bias, then clipped.
  assign sum     = -pprod_r - prod_r + $signed(PROD_W'(pdjs_pkg::ROUND_BIAS));
  assign shifted = sum >>> pdjs_pkg::RND_SHIFT;
  assign tclip   = clip_trq(shifted);

  always_ff @(posedge clk) begin
    unique case (state_r)
      pdjs_pkg::ST_READ: begin
        prod_r     <= prod;
        perr_r     <= perr;
        held_new_r <= qref;
      end
      pdjs_pkg::ST_PMUL: begin
        verr_r  <= $signed(vclip[TRQ_W-1:0]);
        sat_r   <= vclip[TRQ_W];
        pprod_r <= prod;
      end
      pdjs_pkg::ST_DMUL: begin
        prod_r <= prod;
      end
      default: ;
    endcase
  end

  // State memory write: activate stores {angle, 0}; a finished control step
  // stores {angle, reference in use}. The two never coincide.
  assign st_we    = is_act || fin;
  assign st_waddr = fin ? idx_r : in_idx;
  assign st_wdata = fin ? {q_r, held_new_r} : {in_d.angle, {ANG_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (st_we) begin
      vld_r[st_waddr] <= 1'b1;
    end
  end

  // Output register.
  pdjs_pkg::out_item_t out_item_r;

  assign out_valid_nxt = fin ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_item_r.out_joint <= joint_r;
      out_item_r.torque    <= $signed(tclip[TRQ_W-1:0]);
      out_item_r.phase     <= item_phase_r;
      out_item_r.saturated <= sat_r || tclip[TRQ_W];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  // A finished control step always lands in the output register.
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_chan.valid)
    else $error("finished torque did not reach the output register");

  // An accepted control step starts the memory read at once.
  a_ctl_starts: assert property (@(posedge clk) disable iff (!rst_n)
    is_ctl |=> (state_r == pdjs_pkg::ST_READ))
    else $error("control step accepted but sequencer did not start");

  // Hold is left only through an activate command.
  a_hold_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == pdjs_pkg::PHASE_HOLD && !is_act) |=> (phase_r == pdjs_pkg::PHASE_HOLD))
    else $error("phase left hold without an activate");

  // The foot torque check is spent only once the first trajectory is done.
  a_check_spent: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(armed_r) |-> (phase_r != pdjs_pkg::PHASE_FIRST))
    else $error("torque check disarmed while still on first trajectory");

endmodule

>>> rtl/core/pdjs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pdjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pdjs_cfg_regs.sv
// APB-style configuration registers: foot torque threshold and sample rate.
// Depends on pdjs_pkg for widths, reset values and the register map.
module pdjs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pdjs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pdjs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pdjs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output pdjs_pkg::cfg_t                   cfg
);

  logic [pdjs_pkg::THR_W-1:0]  thr_r,  thr_nxt;
  logic [pdjs_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic                        wr_en;
  pdjs_pkg::cfg_reg_t          sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = pdjs_pkg::cfg_reg_t'(paddr[pdjs_pkg::CFG_IDX_BIT]);

  always_comb begin
    thr_nxt  = thr_r;
    rate_nxt = rate_r;
    if (wr_en) begin
      unique case (sel)
        pdjs_pkg::REG_THRESHOLD: thr_nxt  = pwdata[pdjs_pkg::THR_W-1:0];
        pdjs_pkg::REG_RATE:      rate_nxt = pwdata[pdjs_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= pdjs_pkg::THR_RESET;
      rate_r <= pdjs_pkg::RATE_RESET;
    end else begin
      thr_r  <= thr_nxt;
      rate_r <= rate_nxt;
    end
  end

  always_comb begin
    unique case (sel)
      pdjs_pkg::REG_THRESHOLD: prdata = pdjs_pkg::APB_DATA_W'(thr_r);
      pdjs_pkg::REG_RATE:      prdata = pdjs_pkg::APB_DATA_W'(rate_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.threshold   = thr_r;
  assign cfg.sample_rate = rate_r;

endmodule
